### hw/rtl/alpha_levels_remap_unit_assert.svh
// Assertion macros shared by the checker
`ifndef ALPHA_LEVELS_REMAP_UNIT_ASSERT_SVH
`define ALPHA_LEVELS_REMAP_UNIT_ASSERT_SVH

// label: antecedent implies consequent in the same cycle
`define ALR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alr check failed");

// label: antecedent implies consequent in the next cycle
`define ALR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alr check failed");

`endif

### hw/rtl/alr_pkg.sv
`default_nettype none
package alr_pkg;
    localparam int unsigned CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA_LOW     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA_HIGH    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PREMULTIPLIED = 2'd2;
endpackage
`default_nettype wire

### hw/rtl/alr_pixel_if.sv
`default_nettype none
interface alr_pixel_if #(
    parameter int unsigned CHANNEL_BITS = 16
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
    logic [CHANNEL_BITS-1:0] alpha;

    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink (input valid, red, green, blue, alpha, output ready);
endinterface
`default_nettype wire

### hw/rtl/alr_divider.sv
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage.
// Quotient is QW bits wide, divisor DW bits. Tag rides alongside.
module alr_divider #(
    parameter int unsigned QW = 16,
    parameter int unsigned DW = 16,
    parameter int unsigned TW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [QW+DW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    input  wire logic [TW-1:0] tag_in,
    output logic               out_valid,
    output logic [QW-1:0]      quotient,
    output logic               overflow,
    output logic [TW-1:0]      tag_out
);
    // stage s holds partial remainder, full dividend, quotient so far
    logic [QW:0]       v_reg;
    logic [DW:0]       rem_reg  [QW+1];
    logic [QW+DW-1:0]  num_reg  [QW+1];
    logic [DW-1:0]     den_reg  [QW+1];
    logic [QW-1:0]     q_reg    [QW+1];
    logic              ovf_reg  [QW+1];
    logic [TW-1:0]     tag_reg  [QW+1];

    // overflow when top DW bits of dividend >= divisor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[QW-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {1'b0, dividend[QW+DW-1:QW]};
            num_reg[0] <= dividend;
            den_reg[0] <= divisor;
            q_reg[0]   <= '0;
            ovf_reg[0] <= dividend[QW+DW-1:QW] >= divisor;
            tag_reg[0] <= tag_in;
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [DW+1:0] trial_next;
        logic [DW+1:0] shifted_next;
        always_comb
        begin
            shifted_next = {rem_reg[s], num_reg[s][QW-1-s]};
            trial_next   = shifted_next - {2'b00, den_reg[s]};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!trial_next[DW+1])
                begin
                    rem_reg[s+1] <= trial_next[DW:0];
                end
                else
                begin
                    rem_reg[s+1] <= shifted_next[DW:0];
                end
                q_reg[s+1]   <= {q_reg[s][QW-2:0], ~trial_next[DW+1]};
                num_reg[s+1] <= num_reg[s];
                den_reg[s+1] <= den_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
                tag_reg[s+1] <= tag_reg[s];
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign quotient  = q_reg[QW];
    assign overflow  = ovf_reg[QW];
    assign tag_out   = tag_reg[QW];
endmodule
`default_nettype wire

### hw/rtl/alpha_levels_remap_unit.sv
`default_nettype none
// Alpha levels remap with optional premultiplied colour rescale. One pixel is
// accepted per clock while the output side takes results; a result is
// offered after passing the input register, the alpha remap divider
// pipeline, the product register, the three parallel colour rescale
// divider pipelines (each divider CHANNEL_BITS+1 deep) and the output register.
// The whole pipeline advances only when its last stage is empty or taken,
// so a stall freezes every stage and nothing is lost or repeated.
module alpha_levels_remap_unit #(
    parameter int unsigned CHANNEL_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    alr_pixel_if.sink   pix_in,
    alr_pixel_if.source pix_out,
    input  wire logic                                 cfg_we,
    input  wire logic [alr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [CHANNEL_BITS-1:0]              cfg_data
);
    import alr_pkg::*;
    localparam int unsigned W = CHANNEL_BITS;
    localparam logic [W-1:0] FULL = {W{1'b1}};
    // tag carries r,g,b,a and mode
    localparam int unsigned TA = 4*W + 1;

    logic [W-1:0] alpha_low_reg;
    logic [W-1:0] alpha_high_reg;
    logic         premul_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg  <= '0;
            alpha_high_reg <= FULL;
            premul_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ALPHA_LOW:     alpha_low_reg  <= cfg_data;
                REG_ALPHA_HIGH:    alpha_high_reg <= cfg_data;
                REG_PREMULTIPLIED: premul_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;
    assign en = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = en;

    // stage A: classify alpha, form (a-lo)*FULL = ((a-lo)<<W) - (a-lo)
    logic              a_v_reg;
    logic [2*W-1:0]    a_num_reg;
    logic [W-1:0]      a_den_reg;
    logic [1:0]        a_cls_reg;   // 0 divide, 1 zero, 2 full
    logic [TA-1:0]     a_tag_reg;
    logic [W-1:0]      diff_next;
    logic [1:0]        cls_next;

    always_comb
    begin
        diff_next = pix_in.alpha - alpha_low_reg;
        if (pix_in.alpha <= alpha_low_reg)
        begin
            cls_next = 2'd1;
        end
        else if (pix_in.alpha >= alpha_high_reg)
        begin
            cls_next = 2'd2;
        end
        else
        begin
            cls_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= pix_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_num_reg <= {diff_next, {W{1'b0}}} - {{W{1'b0}}, diff_next};
            a_den_reg <= alpha_high_reg - alpha_low_reg;
            a_cls_reg <= cls_next;
            a_tag_reg <= {premul_reg, pix_in.red, pix_in.green, pix_in.blue,
                          pix_in.alpha};
        end
    end

    logic          d1_v;
    logic [W-1:0]  d1_q;
    logic          d1_ovf;
    logic [TA+1:0] d1_tag;

    alr_divider #(.QW(W), .DW(W), .TW(TA + 2)) u_alpha_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(a_v_reg),
        .dividend(a_num_reg),
        .divisor((a_cls_reg == 2'd0) ? a_den_reg : {{(W-1){1'b0}}, 1'b1}),
        .tag_in({a_cls_reg, a_tag_reg}),
        .out_valid(d1_v), .quotient(d1_q), .overflow(d1_ovf), .tag_out(d1_tag)
    );

    // stage B: resolve new alpha, form the three products c*na
    logic [W-1:0] na_next;
    always_comb
    begin
        case (d1_tag[TA+1:TA])
            2'd1:    na_next = '0;
            2'd2:    na_next = FULL;
            default: na_next = d1_ovf ? FULL : d1_q;
        endcase
    end

    logic           b_v_reg;
    logic [2*W-1:0] b_pr_reg, b_pg_reg, b_pb_reg;
    logic [TA-1:0]  b_tag_reg;
    logic [W-1:0]   b_na_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else if (en)
        begin
            b_v_reg <= d1_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_pr_reg  <= d1_tag[4*W-1:3*W] * na_next;
            b_pg_reg  <= d1_tag[3*W-1:2*W] * na_next;
            b_pb_reg  <= d1_tag[2*W-1:W] * na_next;
            b_na_reg  <= na_next;
            b_tag_reg <= d1_tag[TA-1:0];
        end
    end

    // tag for colour dividers: mode, r,g,b, alpha, new alpha
    localparam int unsigned TB = TA + W;
    logic [W-1:0] div_a;
    assign div_a = (b_tag_reg[W-1:0] == '0) ? {{(W-1){1'b0}}, 1'b1} : b_tag_reg[W-1:0];

    logic          r_v, g_v, bl_v;
    logic [W-1:0]  r_q, g_q, bl_q;
    logic          r_o, g_o, bl_o;
    logic [TB-1:0] c_tag;
    logic          g_t, bl_t;

    alr_divider #(.QW(W), .DW(W), .TW(TB)) u_red_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(b_v_reg),
        .dividend(b_pr_reg), .divisor(div_a), .tag_in({b_tag_reg, b_na_reg}),
        .out_valid(r_v), .quotient(r_q), .overflow(r_o), .tag_out(c_tag)
    );
    alr_divider #(.QW(W), .DW(W), .TW(1)) u_green_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(b_v_reg),
        .dividend(b_pg_reg), .divisor(div_a), .tag_in(1'b0),
        .out_valid(g_v), .quotient(g_q), .overflow(g_o), .tag_out(g_t)
    );
    alr_divider #(.QW(W), .DW(W), .TW(1)) u_blue_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(b_v_reg),
        .dividend(b_pb_reg), .divisor(div_a), .tag_in(1'b0),
        .out_valid(bl_v), .quotient(bl_q), .overflow(bl_o), .tag_out(bl_t)
    );

    // output stage
    logic         c_pm, c_azero;
    logic [W-1:0] c_r, c_g, c_b, c_na;
    assign c_na    = c_tag[W-1:0];
    assign c_azero = c_tag[2*W-1:W] == '0;
    assign c_b     = c_tag[3*W-1:2*W];
    assign c_g     = c_tag[4*W-1:3*W];
    assign c_r     = c_tag[5*W-1:4*W];
    assign c_pm    = c_tag[5*W];

    logic [W-1:0] red_reg, green_reg, blue_reg, alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= r_v && g_v && bl_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alpha_reg <= c_na;
            if (!c_pm)
            begin
                red_reg   <= c_r;
                green_reg <= c_g;
                blue_reg  <= c_b;
            end
            else if (c_azero)
            begin
                red_reg   <= '0;
                green_reg <= '0;
                blue_reg  <= '0;
            end
            else
            begin
                red_reg   <= (r_o || g_t || bl_t) && r_o ? FULL : r_q;
                green_reg <= g_o ? FULL : g_q;
                blue_reg  <= bl_o ? FULL : bl_q;
            end
        end
    end

    assign pix_out.valid = out_valid_reg;
    assign pix_out.red   = red_reg;
    assign pix_out.green = green_reg;
    assign pix_out.blue  = blue_reg;
    assign pix_out.alpha = alpha_reg;
endmodule
`default_nettype wire

### hw/rtl/alr_checker.sv
`default_nettype none
`include "alpha_levels_remap_unit_assert.svh"
module alr_checker #(
    parameter int unsigned CHANNEL_BITS = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [CHANNEL_BITS-1:0] out_alpha
);
    // stalled result holds its alpha
    `ALR_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, $stable(out_alpha))
    // stalled result stays offered
    `ALR_ASSERT_NEXT(a_stay, clk, rst_n, out_valid && !out_ready, out_valid)
    // input side open whenever output slot free or taken
    `ALR_ASSERT_IMPL(a_flow, clk, rst_n, !out_valid || out_ready, in_ready)
    // input only blocked by a stalled output
    `ALR_ASSERT_IMPL(a_block, clk, rst_n, !in_ready, out_valid && !out_ready)
endmodule

bind alpha_levels_remap_unit alr_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_alr_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(pix_in.ready),
    .out_valid(pix_out.valid), .out_ready(pix_out.ready), .out_alpha(pix_out.alpha)
);
`default_nettype wire
